// ===== src/tra_pkg.sv =====
// thermocouple reading averager: shared types and constants
// converter word layout, request codes and result field widths
// no dependencies
package tra_pkg;

  localparam int unsigned SPI_W      = 16;
  localparam int unsigned READING_W  = 13;
  localparam int unsigned READING_LSB = 3;
  localparam int unsigned FAULT_BIT  = 2;
  localparam int unsigned MEAN_W     = 17;
  localparam int unsigned SCALE_SHIFT = 4;

  typedef enum logic {
    REQ_WORD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef logic [READING_W-1:0] reading_t;
  typedef logic [MEAN_W-1:0]    mean_t;

endpackage

// ===== src/thermocouple_reading_averager.sv =====
// thermocouple reading averager: boxcar mean over the last good converter readings
// one sequencer drives a shared add/subtract unit for sum updates and the divider
// depends on tra_pkg
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------------------------
//  in      | in_valid_i  | in_stall_o  | req_type_i, spi_word_i
//  out     | out_valid_o | out_stall_i | sample_taken_o, sensor_fault_o, window_empty_o,
//          |             |             | mean_temp_o
//
// a query divides the scaled sum by the count over DIV_W steps, one quotient bit a cycle
// through the shared adder; a converter word evicts the oldest reading if the window is full, then stores if good
// one item is in work at a time; in_stall_o is high from transfer until the result
// is loaded into the output register, which then holds while out_stall_i is high
// reset clears the sequencer, count, sum, oldest position and sets the read permit
// ring entries are not cleared, only ever read after being written
module thermocouple_reading_averager #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [tra_pkg::SPI_W-1:0] spi_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      sample_taken_o,
  output logic                      sensor_fault_o,
  output logic                      window_empty_o,
  output tra_pkg::mean_t            mean_temp_o
);

  localparam int unsigned IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned POS_W  = CNT_W + 1;
  localparam int unsigned SUM_W  = tra_pkg::READING_W + CNT_W;
  localparam int unsigned DIV_W  = SUM_W + tra_pkg::SCALE_SHIFT;
  localparam int unsigned ALU_W  = SUM_W + 1;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVICT = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [IDX_W-1:0]        oldest_q, oldest_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic                    permit_q, permit_d;
  logic [tra_pkg::SPI_W-1:0] word_q, word_d;
  logic                    taken_q, taken_d;
  logic                    fault_q, fault_d;
  logic                    empty_q, empty_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [DIV_W-1:0]        quo_q, quo_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_taken_q, out_fault_q, out_empty_q;
  tra_pkg::mean_t          out_mean_q;

  tra_pkg::reading_t       ring_mem [WINDOW_DEPTH];
  tra_pkg::reading_t       rd_data_q;
  logic                    ring_we;
  logic [IDX_W-1:0]        wr_idx;
  logic [POS_W-1:0]        wr_pos;
  tra_pkg::reading_t       reading;

  logic [ALU_W-1:0]        alu_a, alu_b, alu_y;
  logic                    alu_sub;
  logic [CNT_W:0]          shifted;

  logic                    in_xfer, load_out;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign reading  = word_q[tra_pkg::SPI_W-1:tra_pkg::READING_LSB];
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign wr_pos = POS_W'(oldest_q) + POS_W'(count_q);
  assign wr_idx = (wr_pos >= POS_W'(WINDOW_DEPTH)) ?
                  IDX_W'(wr_pos - POS_W'(WINDOW_DEPTH)) : IDX_W'(wr_pos);

  assign shifted = {rem_q, quo_q[DIV_W-1]};

  // shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_q)
      S_EVICT: begin
        alu_a = ALU_W'(sum_q);
        alu_b = ALU_W'(rd_data_q);
      end
      S_STORE: begin
        alu_a   = ALU_W'(sum_q);
        alu_b   = ALU_W'(reading);
        alu_sub = 1'b0;
      end
      S_DIV: begin
        alu_a = ALU_W'(shifted);
        alu_b = ALU_W'(count_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  always_comb begin
    state_d  = state_q;
    oldest_d = oldest_q;
    count_d  = count_q;
    sum_d    = sum_q;
    permit_d = permit_q;
    word_d   = word_q;
    taken_d  = taken_q;
    fault_d  = fault_q;
    empty_d  = empty_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    step_d   = step_q;
    ring_we  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          word_d  = spi_word_i;
          taken_d = 1'b0;
          fault_d = 1'b0;
          empty_d = 1'b0;
          quo_d   = '0;
          state_d = S_DONE;
          if (req_type_i == tra_pkg::REQ_WORD) begin
            if (permit_q) begin
              permit_d = 1'b0;
              taken_d  = 1'b1;
              fault_d  = spi_word_i[tra_pkg::FAULT_BIT];
              if (count_q >= CNT_W'(WINDOW_DEPTH)) begin
                state_d = S_EVICT;
              end else if (!spi_word_i[tra_pkg::FAULT_BIT]) begin
                state_d = S_STORE;
              end
            end
          end else begin
            permit_d = 1'b1;
            if (count_q == '0) begin
              empty_d = 1'b1;
            end else begin
              quo_d   = {sum_q, {tra_pkg::SCALE_SHIFT{1'b0}}};
              rem_d   = '0;
              step_d  = STEP_W'(DIV_W - 1);
              state_d = S_DIV;
            end
          end
        end
      end
      S_EVICT: begin
        sum_d    = alu_y[SUM_W-1:0];
        count_d  = count_q - CNT_W'(1);
        oldest_d = (oldest_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);
        state_d  = fault_q ? S_DONE : S_STORE;
      end
      S_STORE: begin
        ring_we = 1'b1;
        sum_d   = alu_y[SUM_W-1:0];
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end
      S_DIV: begin
        if (alu_y[ALU_W-1]) begin
          rem_d = shifted[CNT_W-1:0];
        end else begin
          rem_d = alu_y[CNT_W-1:0];
        end
        quo_d = {quo_q[DIV_W-2:0], !alu_y[ALU_W-1]};
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      permit_q    <= 1'b1;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      permit_q    <= permit_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    taken_q <= taken_d;
    fault_q <= fault_d;
    empty_q <= empty_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    if (load_out) begin
      out_taken_q <= taken_q;
      out_fault_q <= fault_q;
      out_empty_q <= empty_q;
      out_mean_q  <= quo_q[tra_pkg::MEAN_W-1:0];
    end
  end

  // reading ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wr_idx] <= reading;
    end
    rd_data_q <= ring_mem[oldest_q];
  end

  assign out_valid_o    = out_valid_q;
  assign sample_taken_o = out_taken_q;
  assign sensor_fault_o = out_fault_q;
  assign window_empty_o = out_empty_q;
  assign mean_temp_o    = out_mean_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("stored count beyond window depth");

  a_oldest_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= IDX_W'(WINDOW_DEPTH - 1))
    else $error("oldest position beyond window depth");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done state");

  a_empty_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> (out_mean_q == '0) && !out_taken_q)
    else $error("empty window result carries a mean or a sample");

  a_store_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STORE |-> count_q < CNT_W'(WINDOW_DEPTH))
    else $error("store into a full window");

endmodule

// ===== tb/thermocouple_reading_averager_tb.sv =====
// testbench for thermocouple_reading_averager: directed table then random word/query traffic
// predicts results by boxcar model, fixed rows by table; checks every field in order
// depends on tra_pkg and thermocouple_reading_averager
module thermocouple_reading_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned RANDOM_ITEMS = 1675;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned LIMIT        = 600000;
  localparam int unsigned MAX_WAIT     = 17;

  typedef struct {
    logic           taken;
    logic           fault;
    logic           empty;
    tra_pkg::mean_t mean;
  } avg_result_t;

  typedef struct {
    tra_pkg::req_type_e req;
    logic [15:0]        word;
    bit                 fixed;
    avg_result_t        res;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic                        req_type_i  = 1'b0;
  logic [tra_pkg::SPI_W-1:0]   spi_word_i  = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        sample_taken_o;
  logic                        sensor_fault_o;
  logic                        window_empty_o;
  tra_pkg::mean_t              mean_temp_o;

  tra_pkg::reading_t    ring_readings [DEPTH];
  int unsigned          head_pos;
  int unsigned          fill_count;
  int unsigned          reading_sum;
  bit                   permit;

  avg_result_t          pending_results [$];
  stim_row_t            directed_rows [$];
  int unsigned          errors;
  int unsigned          watchdog_cycles;
  bit                   tx_burst;
  bit                   rx_burst;

  thermocouple_reading_averager #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .spi_word_i    (spi_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_taken_o(sample_taken_o),
    .sensor_fault_o(sensor_fault_o),
    .window_empty_o(window_empty_o),
    .mean_temp_o   (mean_temp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // boxcar average over the last DEPTH good readings
  function automatic avg_result_t average_step(tra_pkg::req_type_e req, logic [15:0] word);
    avg_result_t       r;
    tra_pkg::reading_t rd;
    r = '{taken: 1'b0, fault: 1'b0, empty: 1'b0, mean: '0};
    if (req == tra_pkg::REQ_WORD) begin
      if (permit) begin
        r.taken = 1'b1;
        r.fault = word[tra_pkg::FAULT_BIT];
        // full window drops its oldest reading even for a faulty word
        if (fill_count >= DEPTH) begin
          reading_sum -= ring_readings[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          fill_count--;
        end
        if (!r.fault) begin
          rd = word[tra_pkg::READING_LSB +: tra_pkg::READING_W];
          ring_readings[(head_pos + fill_count) % DEPTH] = rd;
          reading_sum += rd;
          fill_count++;
        end
        permit = 1'b0;
      end
    end else begin
      permit = 1'b1;
      if (fill_count == 0) begin
        r.empty = 1'b1;
      end else begin
        r.mean = tra_pkg::mean_t'(((reading_sum << tra_pkg::SCALE_SHIFT) / fill_count));
      end
    end
    return r;
  endfunction

  task automatic push_row(tra_pkg::req_type_e req, logic [15:0] word, bit fixed, logic taken,
                          logic fault, logic empty, tra_pkg::mean_t mean);
    stim_row_t row;
    row.req   = req;
    row.word  = word;
    row.fixed = fixed;
    row.res   = '{taken: taken, fault: fault, empty: empty, mean: mean};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic send_item(tra_pkg::req_type_e req, logic [15:0] word, bit fixed,
                           avg_result_t fixed_res);
    int unsigned gap;
    avg_result_t predicted;
    if ($urandom_range(0, 79) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    spi_word_i <= word;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = average_step(req, word);
    if (fixed) predicted = fixed_res;
    pending_results.insert(pending_results.size(), predicted);
  endtask

  task automatic field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    avg_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result transfer, actual taken %0b fault %0b empty %0b mean %0d",
               $time, sample_taken_o, sensor_fault_o, window_empty_o, mean_temp_o);
      errors++;
    end else begin
      want = pending_results.pop_front();
      field_check("sample_taken", want.taken, sample_taken_o);
      field_check("sensor_fault", want.fault, sensor_fault_o);
      field_check("window_empty", want.empty, window_empty_o);
      field_check("mean_temp", want.mean, mean_temp_o);
    end
  endtask

  // result side: random stall before each transfer
  initial begin
    int unsigned stall_cycles;
    forever begin
      if ($urandom_range(0, 79) == 0) rx_burst = !rx_burst;
      stall_cycles = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_result();
    end
  end

  initial begin
    for (watchdog_cycles = 0; watchdog_cycles < LIMIT; watchdog_cycles++) @(posedge clk_i);
    $display("thermocouple_reading_averager_tb: errors");
    $finish;
  end

  initial begin
    avg_result_t        none;
    tra_pkg::req_type_e req;
    logic [15:0]        word;
    none = '{taken: 1'b0, fault: 1'b0, empty: 1'b0, mean: '0};
    for (int i = 0; i < DEPTH; i++) ring_readings[i] = '0;
    head_pos    = 0;
    fill_count  = 0;
    reading_sum = 0;
    permit      = 1'b1;
    errors      = 0;

    // empty query, zero reading, word without permit, faults, max readings, full window
    push_row(tra_pkg::REQ_QUERY, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, '0);
    push_row(tra_pkg::REQ_WORD,  16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, '0);
    push_row(tra_pkg::REQ_WORD,  16'hFFF8, 1'b1, 1'b0, 1'b0, 1'b0, '0);
    push_row(tra_pkg::REQ_QUERY, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    push_row(tra_pkg::REQ_WORD,  16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, '0);
    push_row(tra_pkg::REQ_QUERY, 16'h1234, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    for (int i = 0; i < 8; i++) begin
      push_row(tra_pkg::REQ_WORD,  16'hFFF8, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      push_row(tra_pkg::REQ_QUERY, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    end
    push_row(tra_pkg::REQ_WORD,  16'hFFF8, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    push_row(tra_pkg::REQ_QUERY, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 17'h1FFF0);
    push_row(tra_pkg::REQ_WORD,  16'h0004, 1'b1, 1'b1, 1'b1, 1'b0, '0);
    push_row(tra_pkg::REQ_QUERY, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req, directed_rows[i].word, directed_rows[i].fixed,
                directed_rows[i].res);
    end

    // mostly word/query pairs, with repeated words and queries mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 85) begin
        req = permit ? tra_pkg::REQ_WORD : tra_pkg::REQ_QUERY;
      end else begin
        req = tra_pkg::req_type_e'($urandom_range(0, 1));
      end
      word = 16'($urandom);
      if (req == tra_pkg::REQ_WORD) begin
        if ($urandom_range(0, 5) != 0) word[tra_pkg::FAULT_BIT] = 1'b0;
        case ($urandom_range(0, 7))
          0: word[tra_pkg::READING_LSB +: tra_pkg::READING_W] = '1;
          1: word[tra_pkg::READING_LSB +: tra_pkg::READING_W] = '0;
          default: ;
        endcase
      end
      send_item(req, word, 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("thermocouple_reading_averager_tb: clean");
    end else begin
      $display("thermocouple_reading_averager_tb: errors");
    end
    $finish;
  end

endmodule

// ===== thermocouple_reading_averager.f =====
src/tra_pkg.sv
src/thermocouple_reading_averager.sv
tb/thermocouple_reading_averager_tb.sv
